// ----- rtl/multi_sensor_scan_sequencer_top_defines.svh -----
// Assertion helpers for the scan sequencer. Both forms sample on clk and
// are switched off while rst_n is low.
`ifndef MULTI_SENSOR_SCAN_SEQUENCER_TOP_DEFINES_SVH
`define MULTI_SENSOR_SCAN_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define MSSQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sequencer check failed");

`define MSSQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`else

`define MSSQ_ASSERT(lbl, prop)

`define MSSQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/mssq_pkg.sv -----
package mssq_pkg;

  localparam int NUM_SENSORS = 5;
  localparam int SLOT_W      = 3;
  localparam int ADDR_W      = 7;
  localparam int ADDRS_W     = NUM_SENSORS * ADDR_W;
  localparam int ERR_W       = 8;
  localparam int STATE_W     = 3;

  localparam logic [SLOT_W-1:0]  SLOT_NONE       = SLOT_W'(NUM_SENSORS);
  localparam logic [ADDRS_W-1:0] ADDRS_RESET     = 35'h142648890;
  localparam logic [ERR_W-1:0]   ERR_LIMIT_RESET = 8'd10;
  localparam logic [ERR_W-1:0]   ERR_MAX         = {ERR_W{1'b1}};

  // configuration register indexes
  localparam logic CFG_SENSOR_ADDRS = 1'b0;
  localparam logic CFG_ERROR_LIMIT  = 1'b1;

  typedef enum logic [STATE_W-1:0] {
    ST_IDLE    = 3'd0,
    ST_NEEDCAL = 3'd1,
    ST_WAITCAL = 3'd2,
    ST_WAITSUB = 3'd3,
    ST_READSUB = 3'd4
  } run_state_t;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_PAUSE = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_CONT  = 2'd3
  } action_t;

  // address of a slot, zero for no slot
  function automatic logic [ADDR_W-1:0] addr_of(logic [ADDRS_W-1:0] addrs,
                                                 logic [SLOT_W-1:0] slot);
    logic [ADDR_W-1:0] a;
    a = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (slot == SLOT_W'(i)) begin
        a = addrs[i*ADDR_W +: ADDR_W];
      end
    end
    return a;
  endfunction

  // slots that hold a nonzero address
  function automatic logic [NUM_SENSORS-1:0] present_mask(logic [ADDRS_W-1:0] addrs);
    logic [NUM_SENSORS-1:0] m;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      m[i] = (addrs[i*ADDR_W +: ADDR_W] != '0);
    end
    return m;
  endfunction

  // first active slot after 'from', wrapping; SLOT_NONE starts at slot 0
  function automatic logic [SLOT_W-1:0] next_slot(logic [NUM_SENSORS-1:0] act,
                                                   logic [SLOT_W-1:0] from);
    logic [SLOT_W:0]   start;
    logic [SLOT_W:0]   pos;
    logic [SLOT_W-1:0] res;
    start = (from >= SLOT_NONE) ? '0 : ({1'b0, from} + (SLOT_W+1)'(1));
    res   = SLOT_NONE;
    // scan from the far end so the nearest hit wins
    for (int k = NUM_SENSORS - 1; k >= 0; k--) begin
      pos = start + (SLOT_W+1)'(k);
      if (pos >= (SLOT_W+1)'(NUM_SENSORS)) begin
        pos = pos - (SLOT_W+1)'(NUM_SENSORS);
      end
      if (act[pos[SLOT_W-1:0]]) begin
        res = pos[SLOT_W-1:0];
      end
    end
    return res;
  endfunction

endpackage

// ----- rtl/multi_sensor_scan_sequencer_top.sv -----
// Channel  | Handshake           | Word
// ---------+---------------------+-------------------------------------------
// in       | in_valid/in_ready   | action, bus request and transfer outcomes
// out      | out_valid/out_ready | run state, slot, address, request flags
// cfg      | cfg_wr_en           | cfg_index selects addresses or error limit
//
// One word per cycle while in_ready is high: the whole step is one
// combinational pass from the sequencer state registers into the output
// register, which drives out_*. in_ready drops only while a result waits
// in the output register and out_ready is low. Reset (rst_n low at a clock
// edge) clears the run state, slot, counters and active set, and loads the
// default addresses and error limit.
`include "multi_sensor_scan_sequencer_top_defines.svh"

module multi_sensor_scan_sequencer_top
  import mssq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_action,
  input  logic                   in_read_started,
  input  logic                   in_status_ok,
  input  logic                   in_status_new_data,
  input  logic [2:0]             in_status_subpage,
  input  logic                   in_dma_error,
  input  logic                   in_dma_done,
  input  logic                   in_dma_len_ok,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATE_W-1:0]     out_run_state,
  output logic [SLOT_W-1:0]      out_sensor_index,
  output logic [ADDR_W-1:0]      out_bus_addr,
  output logic                   out_issue_cal_read,
  output logic                   out_issue_status_read,
  output logic                   out_issue_image_read,
  output logic                   out_store_conf,
  output logic                   out_store_image,
  output logic                   out_sensor_dropped,
  output logic                   out_bus_reset,
  output logic [NUM_SENSORS-1:0] out_active_mask,

  input  logic                   cfg_wr_en,
  input  logic                   cfg_index,
  input  logic [ADDRS_W-1:0]     cfg_wdata
);

  // configuration
  logic [ADDRS_W-1:0]     addrs_r;
  logic [ERR_W-1:0]       limit_r;

  // sequencer state
  run_state_t             run_r,   run_nxt;
  run_state_t             saved_r, saved_nxt;
  logic [SLOT_W-1:0]      slot_r,  slot_nxt;
  logic                   want_r,  want_nxt;
  logic [ERR_W-1:0]       err_r,   err_nxt;
  logic [NUM_SENSORS-1:0] act_r,   act_nxt;

  // step results
  logic [SLOT_W-1:0]      acted;
  logic                   f_cal, f_stat, f_img, f_sconf, f_simg, f_drop, f_rst;
  logic                   check;
  logic [SLOT_W-1:0]      nx;

  logic                   out_valid_r;
  logic [STATE_W-1:0]     out_run_state_r;
  logic [SLOT_W-1:0]      out_sensor_index_r;
  logic [ADDR_W-1:0]      out_bus_addr_r;
  logic                   out_cal_r, out_stat_r, out_img_r;
  logic                   out_sconf_r, out_simg_r, out_drop_r, out_rst_r;
  logic [NUM_SENSORS-1:0] out_active_mask_r;

  logic                   in_acc;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addrs_r <= ADDRS_RESET;
      limit_r <= ERR_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SENSOR_ADDRS: addrs_r <= cfg_wdata;
        CFG_ERROR_LIMIT:  limit_r <= cfg_wdata[ERR_W-1:0];
        default:          addrs_r <= addrs_r;
      endcase
    end
  end

  always_comb begin
    run_nxt   = run_r;
    saved_nxt = saved_r;
    slot_nxt  = slot_r;
    want_nxt  = want_r;
    err_nxt   = err_r;
    act_nxt   = act_r;
    acted     = slot_r;
    f_cal     = 1'b0;
    f_stat    = 1'b0;
    f_img     = 1'b0;
    f_sconf   = 1'b0;
    f_simg    = 1'b0;
    f_drop    = 1'b0;
    f_rst     = 1'b0;
    check     = 1'b0;
    nx        = SLOT_NONE;

    case (action_t'(in_action))
      ACT_PAUSE: begin
        saved_nxt = run_r;
        run_nxt   = ST_IDLE;
      end
      ACT_STOP: begin
        saved_nxt = ST_NEEDCAL;
        run_nxt   = ST_IDLE;
      end
      ACT_CONT: begin
        err_nxt = '0;
        if (saved_r == ST_WAITSUB || saved_r == ST_READSUB) begin
          run_nxt = ST_WAITSUB;
        end else begin
          f_rst    = 1'b1;
          act_nxt  = present_mask(addrs_r);
          run_nxt  = ST_NEEDCAL;
          slot_nxt = SLOT_NONE;
        end
        acted = slot_nxt;
      end
      ACT_TICK: begin
        if (run_r != ST_IDLE) begin
          // pick a slot first when none is selected; an empty set halts
          if (slot_r >= SLOT_NONE) begin
            nx = next_slot(act_r, SLOT_NONE);
            if (nx == SLOT_NONE) begin
              saved_nxt = ST_NEEDCAL;
              run_nxt   = ST_IDLE;
            end
            slot_nxt = nx;
          end
          acted = slot_nxt;
          if (slot_nxt < SLOT_NONE) begin
            check = 1'b1;
            case (run_r)
              ST_NEEDCAL: begin
                f_cal = 1'b1;
                if (in_read_started) begin
                  err_nxt = '0;
                  run_nxt = ST_WAITCAL;
                end else if (err_nxt != ERR_MAX) begin
                  err_nxt = err_nxt + ERR_W'(1);
                end
              end
              ST_WAITCAL: begin
                if (in_dma_error) begin
                  run_nxt = ST_NEEDCAL;
                end else if (in_dma_done) begin
                  if (!in_dma_len_ok) begin
                    run_nxt = ST_NEEDCAL;
                  end else begin
                    f_sconf = 1'b1;
                    nx      = next_slot(act_nxt, slot_nxt);
                    if (nx == SLOT_NONE) begin
                      saved_nxt = ST_NEEDCAL;
                    end
                    err_nxt  = '0;
                    // wrapping round means calibration is done for all
                    run_nxt  = (nx >= SLOT_NONE || nx <= slot_nxt) ? ST_WAITSUB
                                                                   : ST_NEEDCAL;
                    slot_nxt = nx;
                    check    = 1'b0;
                  end
                end
              end
              ST_WAITSUB: begin
                f_stat = 1'b1;
                if (in_status_ok && in_status_new_data) begin
                  if (in_status_subpage == {2'b00, want_nxt}) begin
                    err_nxt = '0;
                    if (!want_nxt) begin
                      // skip subpage 0 on this sensor, move on
                      nx = next_slot(act_nxt, slot_nxt);
                      if (nx == SLOT_NONE) begin
                        saved_nxt = ST_NEEDCAL;
                        run_nxt   = ST_IDLE;
                      end
                      if (nx >= SLOT_NONE || nx <= slot_nxt) begin
                        want_nxt = 1'b1;
                      end
                      slot_nxt = nx;
                    end else begin
                      f_img = 1'b1;
                      if (in_read_started) begin
                        run_nxt = ST_READSUB;
                      end else if (err_nxt != ERR_MAX) begin
                        err_nxt = err_nxt + ERR_W'(1);
                      end
                    end
                  end
                end else if (err_nxt != ERR_MAX) begin
                  err_nxt = err_nxt + ERR_W'(1);
                end
              end
              ST_READSUB: begin
                if (in_dma_error) begin
                  run_nxt = ST_WAITSUB;
                end else if (in_dma_done) begin
                  if (!in_dma_len_ok) begin
                    if (err_nxt != ERR_MAX) begin
                      err_nxt = err_nxt + ERR_W'(1);
                    end
                  end else begin
                    err_nxt = '0;
                    f_simg  = 1'b1;
                    nx      = next_slot(act_nxt, slot_nxt);
                    if (nx == SLOT_NONE) begin
                      saved_nxt = ST_NEEDCAL;
                    end
                    if (nx >= SLOT_NONE || nx <= slot_nxt) begin
                      want_nxt = 1'b0;
                    end
                    slot_nxt = nx;
                  end
                  run_nxt = ST_WAITSUB;
                end
              end
              default: begin
                check = 1'b0;
              end
            endcase

            // drop the sensor once its error count passes the limit
            if (check && err_nxt > limit_r && slot_nxt < SLOT_NONE) begin
              err_nxt = '0;
              act_nxt = act_nxt & ~(NUM_SENSORS'(1) << slot_nxt);
              f_drop  = 1'b1;
              acted   = slot_nxt;
              nx      = next_slot(act_nxt, slot_nxt);
              if (nx == SLOT_NONE) begin
                saved_nxt = ST_NEEDCAL;
                run_nxt   = ST_IDLE;
              end
              slot_nxt = nx;
            end
          end
        end
      end
      default: begin
        run_nxt = run_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= ST_IDLE;
      saved_r <= ST_IDLE;
      slot_r  <= SLOT_NONE;
      want_r  <= 1'b0;
      err_r   <= '0;
      act_r   <= '0;
    end else if (in_acc) begin
      run_r   <= run_nxt;
      saved_r <= saved_nxt;
      slot_r  <= slot_nxt;
      want_r  <= want_nxt;
      err_r   <= err_nxt;
      act_r   <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_run_state_r    <= run_nxt;
      out_sensor_index_r <= acted;
      out_bus_addr_r     <= addr_of(addrs_r, acted);
      out_cal_r          <= f_cal;
      out_stat_r         <= f_stat;
      out_img_r          <= f_img;
      out_sconf_r        <= f_sconf;
      out_simg_r         <= f_simg;
      out_drop_r         <= f_drop;
      out_rst_r          <= f_rst;
      out_active_mask_r  <= act_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_run_state         = out_run_state_r;
  assign out_sensor_index      = out_sensor_index_r;
  assign out_bus_addr          = out_bus_addr_r;
  assign out_issue_cal_read    = out_cal_r;
  assign out_issue_status_read = out_stat_r;
  assign out_issue_image_read  = out_img_r;
  assign out_store_conf        = out_sconf_r;
  assign out_store_image       = out_simg_r;
  assign out_sensor_dropped    = out_drop_r;
  assign out_bus_reset         = out_rst_r;
  assign out_active_mask       = out_active_mask_r;

  // an image read always rides on the status read of the same tick
  `MSSQ_ASSERT(a_one_request,
    !out_valid_r || ($onehot0({out_cal_r, out_stat_r}) && (!out_img_r || out_stat_r)))
  `MSSQ_ASSERT(a_slot_range, slot_r <= SLOT_NONE)
  `MSSQ_ASSERT(a_drop_clears_bit,
    !(out_valid_r && out_drop_r) ||
    ((out_active_mask_r >> out_sensor_index_r) & NUM_SENSORS'(1)) == '0)
  `MSSQ_ASSERT(a_reset_restarts,
    !(out_valid_r && out_rst_r) ||
    (out_run_state_r == ST_NEEDCAL && out_sensor_index_r == SLOT_NONE))
  `MSSQ_ASSERT_NEXT(a_idle_tick_quiet,
    in_acc && in_action == ACT_TICK && run_r == ST_IDLE,
    !out_cal_r && !out_stat_r && !out_img_r && !out_sconf_r && !out_simg_r &&
    !out_drop_r)

endmodule
